/* hw/rtl/sfn_pkg.sv */
// Shared types and constants for the 8.3 short name converter.
`timescale 1ns / 1ps

package sfn_pkg;

  localparam int BASE_LEN   = 8;
  localparam int EXT_LEN    = 3;
  localparam int NAME_LEN   = BASE_LEN + EXT_LEN;
  localparam int BASE_CNT_W = $clog2(BASE_LEN + 1);
  localparam int EXT_CNT_W  = $clog2(EXT_LEN + 1);
  localparam int IDX_W      = $clog2(NAME_LEN);
  localparam int POS_W      = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h20;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_name;
  } char_item_t;

  typedef struct packed {
    logic [7:0]       name_char;
    logic [POS_W-1:0] position;
    logic             last;
    logic             status;
  } name_item_t;

  // Finished name handed from the builder to the output sequencer
  typedef struct packed {
    logic                         load;
    logic                         err;
    logic [NAME_LEN-1:0][7:0]     bytes;
  } snap_t;

endpackage

/* hw/rtl/sfn_builder.sv */
// Character classification, counters and name store of the 8.3 converter.
`timescale 1ns / 1ps

module sfn_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  sfn_pkg::char_item_t item,
  output sfn_pkg::snap_t      snap
);

  logic [sfn_pkg::NAME_LEN-1:0][7:0]  store, store_next;
  logic [sfn_pkg::BASE_CNT_W-1:0]     base_count, base_count_next;
  logic [sfn_pkg::EXT_CNT_W-1:0]      ext_count, ext_count_next;
  logic                               dot_seen, dot_seen_next;
  logic                               reject_flag, reject_flag_next;
  logic                               any_char_seen, any_char_seen_next;
  logic                               allowed;
  logic                               lower;
  logic [7:0]                         up_char;
  logic [sfn_pkg::IDX_W-1:0]          wr_idx;

  // Classify the character
  always_comb begin
    lower   = (item.ch >= "a") && (item.ch <= "z");
    allowed = ((item.ch >= "0") && (item.ch <= "9")) ||
              ((item.ch >= "A") && (item.ch <= "Z")) || lower ||
              (item.ch == "_") || (item.ch == "-") ||
              (item.ch == "$") || (item.ch == "~");
    up_char = lower ? (item.ch - sfn_pkg::CASE_SHIFT) : item.ch;
    wr_idx  = dot_seen ?
              (sfn_pkg::IDX_W'(sfn_pkg::BASE_LEN) + sfn_pkg::IDX_W'(ext_count)) :
              sfn_pkg::IDX_W'(base_count);
  end

  // Update counters and store for one item
  always_comb begin
    store_next         = store;
    base_count_next    = base_count;
    ext_count_next     = ext_count;
    dot_seen_next      = dot_seen;
    reject_flag_next   = reject_flag;
    any_char_seen_next = any_char_seen;
    if (take) begin
      if (item.end_of_name) begin
        store_next         = {sfn_pkg::NAME_LEN{sfn_pkg::PAD_CHAR}};
        base_count_next    = '0;
        ext_count_next     = '0;
        dot_seen_next      = 1'b0;
        reject_flag_next   = 1'b0;
        any_char_seen_next = 1'b0;
      end else begin
        any_char_seen_next = 1'b1;
        if (!reject_flag) begin
          priority if (item.ch == sfn_pkg::DOT_CHAR) begin
            if (dot_seen) reject_flag_next = 1'b1;
            else          dot_seen_next    = 1'b1;
          end else if (!allowed) begin
            reject_flag_next = 1'b1;
          end else if (!dot_seen) begin
            if (base_count >= sfn_pkg::BASE_CNT_W'(sfn_pkg::BASE_LEN)) begin
              reject_flag_next = 1'b1;
            end else begin
              store_next[wr_idx] = up_char;
              base_count_next    = base_count + 1'b1;
            end
          end else begin
            if (ext_count >= sfn_pkg::EXT_CNT_W'(sfn_pkg::EXT_LEN)) begin
              reject_flag_next = 1'b1;
            end else begin
              store_next[wr_idx] = up_char;
              ext_count_next     = ext_count + 1'b1;
            end
          end
        end
      end
    end
  end

  // Hand the finished name over on the terminator
  always_comb begin
    snap.load  = take && item.end_of_name;
    snap.err   = reject_flag || !any_char_seen;
    snap.bytes = store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store         <= {sfn_pkg::NAME_LEN{sfn_pkg::PAD_CHAR}};
      base_count    <= '0;
      ext_count     <= '0;
      dot_seen      <= 1'b0;
      reject_flag   <= 1'b0;
      any_char_seen <= 1'b0;
    end else begin
      store         <= store_next;
      base_count    <= base_count_next;
      ext_count     <= ext_count_next;
      dot_seen      <= dot_seen_next;
      reject_flag   <= reject_flag_next;
      any_char_seen <= any_char_seen_next;
    end
  end

endmodule

/* hw/rtl/sfn_drain.sv */
// Output sequencer: holds a finished name and emits its bytes one item a cycle while name_stall is low.
`timescale 1ns / 1ps

module sfn_drain (
  input  logic                clk,
  input  logic                rst,
  input  sfn_pkg::snap_t      snap,
  output logic                busy,
  output logic                name_valid,
  input  logic                name_stall,
  output sfn_pkg::name_item_t name_item
);

  logic [sfn_pkg::NAME_LEN-1:0][7:0] shift_buf;
  logic [sfn_pkg::IDX_W-1:0]         idx;
  logic                              err;
  logic                              slot_free;
  logic                              final_byte;

  assign slot_free  = !name_valid || !name_stall;
  assign final_byte = err || (idx == sfn_pkg::IDX_W'(sfn_pkg::NAME_LEN - 1));

  // Control: busy flag, byte index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      err        <= 1'b0;
      name_valid <= 1'b0;
    end else begin
      // advance the output slot
      if (slot_free) begin
        name_valid <= busy;
        if (busy) begin
          idx <= idx + 1'b1;
          if (final_byte) busy <= 1'b0;
        end
      end
      // take a new name while idle
      if (snap.load) begin
        busy <= 1'b1;
        idx  <= '0;
        err  <= snap.err;
      end
    end
  end

  // Payload: shift the name out low byte first
  always_ff @(posedge clk) begin
    if (slot_free && busy) begin
      name_item.name_char <= err ? sfn_pkg::PAD_CHAR : shift_buf[0];
      name_item.position  <= err ? '0 : sfn_pkg::POS_W'(idx);
      name_item.last      <= final_byte;
      name_item.status    <= err;
      shift_buf <= {sfn_pkg::PAD_CHAR, shift_buf[sfn_pkg::NAME_LEN-1:1]};
    end
    if (snap.load) begin
      shift_buf <= snap.bytes;
    end
  end

endmodule

/* hw/rtl/short_filename_83_converter.sv */
// Top level of the 8.3 short name converter.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   char     | char_valid / char_stall | char_item: ch, end_of_name
//   name     | name_valid / name_stall | name_item: name_char, position, last, status
//
// Characters go through an input register and are absorbed at one per cycle unless the input stalls.
// A terminator hands the name to the output sequencer, which gives 11 items
// (one on error) at one per cycle while name_stall is low; the next name's characters overlap with it.
// A terminator waits in the input register while the sequencer is still busy.
// Reset is synchronous and clears the store to spaces.
`timescale 1ns / 1ps

module short_filename_83_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  sfn_pkg::char_item_t char_item,
  output logic                name_valid,
  input  logic                name_stall,
  output sfn_pkg::name_item_t name_item
);

  sfn_pkg::char_item_t in_q;
  logic                in_valid_q;
  logic                take;
  logic                drain_busy;
  sfn_pkg::snap_t      snap;

  // Hold a terminator while the previous name is still going out
  assign take       = in_valid_q && !(in_q.end_of_name && drain_busy);
  assign char_stall = in_valid_q && !take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!char_stall) begin
      in_valid_q <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall) begin
      in_q <= char_item;
    end
  end

  sfn_builder u_builder (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_q),
    .snap (snap)
  );

  sfn_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .snap       (snap),
    .busy       (drain_busy),
    .name_valid (name_valid),
    .name_stall (name_stall),
    .name_item  (name_item)
  );

endmodule

/* hw/rtl/sfn_checker.sv */
// Port-level checks for the 8.3 short name converter, bound to the top level.
`timescale 1ns / 1ps

module sfn_checker (
  input logic                clk,
  input logic                rst,
  input logic                char_valid,
  input logic                char_stall,
  input sfn_pkg::char_item_t char_item,
  input logic                name_valid,
  input logic                name_stall,
  input sfn_pkg::name_item_t name_item
);

  // Input backs up only behind a terminator taken the cycle before
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(char_stall) |->
      $past(char_valid && !char_stall && char_item.end_of_name))
    else $error("input stalled without a terminator");

  // An error is a single item that closes the run
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    name_valid && name_item.status |->
      name_item.last && (name_item.position == '0) &&
      (name_item.name_char == sfn_pkg::PAD_CHAR))
    else $error("error item malformed");

  // A good name ends on the final byte position
  a_good_last: assert property (@(posedge clk) disable iff (rst)
    name_valid && !name_item.status && name_item.last |->
      name_item.position == sfn_pkg::POS_W'(sfn_pkg::NAME_LEN - 1))
    else $error("name closed at wrong position");

  // Bytes of a name follow without gaps in rising position
  a_next_byte: assert property (@(posedge clk) disable iff (rst)
    name_valid && !name_stall && !name_item.last |=>
      name_valid && !name_item.status &&
      (name_item.position == $past(name_item.position) + 4'd1))
    else $error("name bytes out of sequence");

  // A stalled output item stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    name_valid && name_stall |=> name_valid && $stable(name_item))
    else $error("stalled item changed");

endmodule

bind short_filename_83_converter sfn_checker u_sfn_checker (.*);
